[src/xcfr_pkg.sv]
// Shared types and constants of the XOR-checked frame receiver.
package xcfr_pkg;

  localparam int MAX_LEN    = 32;
  localparam int DATA_DEPTH = 30;
  localparam int IDX_W      = 5;
  localparam int RAM_AW     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [7:0] LEN_MIN   = 8'd3;
  localparam logic [7:0] LEN_LIMIT =
    8'((MAX_LEN < DATA_DEPTH + 2) ? MAX_LEN : DATA_DEPTH + 2);

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_OWN_ONLY = 1'd1;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_CHK_ERR = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_SOURCE = 3'd0,
    PH_LENGTH = 3'd1,
    PH_DEST   = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } ph_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_LOAD = 2'd2
  } bk_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       src;
    logic [7:0]       dst;
    logic [IDX_W-1:0] cnt;
    logic             bank;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

[src/xcfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/xcfr_front.sv]
// Frame parser: takes bus words, buffers data bytes, queues result commands.
module xcfr_front
  import xcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_rx_byte,
  output logic              in_full,
  input  logic [7:0]        own_address,
  input  logic              filter_own_only,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd,
  input  rel_t              rel,
  output logic              ram_we,
  output logic [RAM_AW-1:0] ram_waddr,
  output logic [7:0]        ram_wdata
);

  ph_t              ph_r, ph_nxt;
  logic [7:0]       src_r, src_nxt;
  logic [7:0]       dst_r, dst_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [IDX_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic             wbank_r, wbank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_SOURCE;
      src_r   <= '0;
      dst_r   <= '0;
      xor_r   <= '0;
      left_r  <= '0;
      widx_r  <= '0;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      ph_r    <= ph_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      xor_r   <= xor_nxt;
      left_r  <= left_nxt;
      widx_r  <= widx_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    xor_nxt   = xor_r;
    left_nxt  = left_r;
    widx_nxt  = widx_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    q_push    = 1'b0;
    q_cmd     = '{kind: KIND_DATA, src: src_r, dst: dst_r, cnt: widx_r, bank: wbank_r};
    ram_we    = 1'b0;
    ram_waddr = {wbank_r, widx_r};
    ram_wdata = in_rx_byte;

    // stall dest and data words while their bank is still being read out
    in_full = q_full || (((ph_r == PH_DEST) || (ph_r == PH_DATA)) && busy_r[wbank_r]);
    acc     = in_push && !in_full;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (acc) begin
      unique case (ph_r)
        PH_LENGTH: begin
          xor_nxt = xor_r ^ in_rx_byte;
          if ((in_rx_byte < LEN_MIN) || (in_rx_byte > LEN_LIMIT)) begin
            q_push     = 1'b1;
            q_cmd.kind = KIND_LEN_ERR;
            q_cmd.dst  = '0;
            ph_nxt     = PH_SOURCE;
          end else begin
            left_nxt = IDX_W'(in_rx_byte - 8'd2);
            ph_nxt   = PH_DEST;
          end
        end
        PH_DEST: begin
          dst_nxt  = in_rx_byte;
          xor_nxt  = xor_r ^ in_rx_byte;
          widx_nxt = '0;
          ph_nxt   = PH_DATA;
        end
        PH_DATA: begin
          ram_we   = 1'b1;
          widx_nxt = IDX_W'(widx_r + 1'b1);
          xor_nxt  = xor_r ^ in_rx_byte;
          left_nxt = IDX_W'(left_r - 1'b1);
          if (left_r == IDX_W'(1)) begin
            ph_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (xor_r != in_rx_byte) begin
            q_push     = 1'b1;
            q_cmd.kind = KIND_CHK_ERR;
          end else if (!filter_own_only || (dst_r == own_address)) begin
            q_push            = 1'b1;
            busy_nxt[wbank_r] = 1'b1;
            wbank_nxt         = !wbank_r;
          end
          ph_nxt = PH_SOURCE;
        end
        default: begin
          src_nxt  = in_rx_byte;
          xor_nxt  = in_rx_byte;
          dst_nxt  = '0;
          left_nxt = '0;
          widx_nxt = '0;
          ph_nxt   = PH_LENGTH;
        end
      endcase
    end
  end

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !busy_r[wbank_r])
    else $error("data written into a bank still being read");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && (q_cmd.kind == KIND_DATA)) |-> (q_cmd.cnt != '0))
    else $error("data command without data bytes");

endmodule

[src/xcfr_cmdq.sv]
// Short command queue between the parser and the result sequencer.
module xcfr_cmdq
  import xcfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r, rptr_r;
  logic [CMDQ_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= CMDQ_AW'(wptr_r + 1'b1);
      end
      if (do_pop) begin
        rptr_r <= CMDQ_AW'(rptr_r + 1'b1);
      end
      cnt_r <= (CMDQ_AW+1)'(cnt_r + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0));
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (CMDQ_AW+1)'(CMDQ_DEPTH))
    else $error("command queue overfilled");

endmodule

[src/xcfr_back.sv]
// Result sequencer: expands queued commands into result words.
module xcfr_back
  import xcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output rel_t              rel,
  output logic              ram_re,
  output logic [RAM_AW-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_source_id,
  output logic [7:0]        out_dest_id,
  output logic [4:0]        out_data_index,
  output logic [7:0]        out_data_byte,
  output logic              out_last
);

  bk_t              st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovld_r;
  kind_t            okind_r;
  logic [7:0]       osrc_r, odst_r, obyte_r;
  logic [IDX_W-1:0] oidx_r;
  logic             olast_r;
  logic             load;
  kind_t            lkind;
  logic [7:0]       lbyte;
  logic [IDX_W-1:0] lidx;
  logic             llast;
  logic             at_last;

  assign at_last = (idx_r == IDX_W'(q_cmd.cnt - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (load) begin
        ovld_r <= 1'b1;
      end else if (out_pop && ovld_r) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      okind_r <= lkind;
      osrc_r  <= q_cmd.src;
      odst_r  <= q_cmd.dst;
      oidx_r  <= lidx;
      obyte_r <= lbyte;
      olast_r <= llast;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    rel       = '{valid: 1'b0, bank: q_cmd.bank};
    ram_re    = 1'b0;
    ram_raddr = {q_cmd.bank, idx_r};
    load      = 1'b0;
    lkind     = q_cmd.kind;
    lbyte     = '0;
    lidx      = '0;
    llast     = 1'b1;

    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == KIND_DATA) begin
            idx_nxt = '0;
            st_nxt  = BK_READ;
          end else if (!ovld_r) begin
            load  = 1'b1;
            q_pop = 1'b1;
          end
        end
      end
      BK_READ: begin
        if (!ovld_r) begin
          ram_re = 1'b1;
          st_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        load  = 1'b1;
        lkind = KIND_DATA;
        lbyte = ram_rdata;
        lidx  = idx_r;
        llast = at_last;
        if (at_last) begin
          q_pop     = 1'b1;
          rel.valid = 1'b1;
          st_nxt    = BK_IDLE;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
          st_nxt  = BK_READ;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign out_empty      = !ovld_r;
  assign out_kind       = okind_r;
  assign out_source_id  = osrc_r;
  assign out_dest_id    = odst_r;
  assign out_data_index = oidx_r;
  assign out_data_byte  = obyte_r;
  assign out_last       = olast_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_LOAD) |-> !ovld_r)
    else $error("result word overwritten");

  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (st_r == BK_LOAD))
    else $error("read data not captured");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop of empty command queue");

endmodule

[src/xor_checked_frame_receiver.sv]
// Path: after its checksum word, a frame's data results pass the command queue, buffer read
// and the output register; error words pass the command queue and the output register.
// Throughput: input takes 1 word per cycle; the result sequencer reads the next buffer byte
// only once the output register is free. Input stalls only when the command queue is full
// or the bank being filled is still being read out. Reset: synchronous, active low, clears
// parser, queue, sequencer and config. Top level of the XOR-checked frame receiver.
module xor_checked_frame_receiver
  import xcfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_rx_byte,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_source_id,
  output logic [7:0]           out_dest_id,
  output logic [4:0]           out_data_index,
  output logic [7:0]           out_data_byte,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic              own_r;
  logic [7:0]        own_addr_r;
  logic              q_full, q_push, q_pop, q_empty;
  cmd_t              q_wcmd, q_rcmd;
  rel_t              rel;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      own_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:     own_addr_r <= cfg_wdata;
        REG_FILTER_OWN_ONLY: own_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  xcfr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_rx_byte      (in_rx_byte),
    .in_full         (in_full),
    .own_address     (own_addr_r),
    .filter_own_only (own_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_wcmd),
    .rel             (rel),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  xcfr_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wcmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_rcmd)
  );

  xcfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  xcfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_rcmd),
    .q_pop          (q_pop),
    .rel            (rel),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_source_id  (out_source_id),
    .out_dest_id    (out_dest_id),
    .out_data_index (out_data_index),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last)
  );

endmodule
